// File: rtl/rat_pkg.sv
// Package with operation codes and shared types for the rational accumulator ALU.
package rat_pkg;

    localparam int W = 32;

    localparam logic [2:0] OP_LOAD     = 3'd0;
    localparam logic [2:0] OP_ADD      = 3'd1;
    localparam logic [2:0] OP_MUL      = 3'd2;
    localparam logic [2:0] OP_DIV      = 3'd3;
    localparam logic [2:0] OP_SIMPLIFY = 3'd4;

    typedef logic [W-1:0] word_t;

    // Request and response of the shared divider.
    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quot;
        word_t rem;
    } div_rsp_t;

endpackage

// File: rtl/rat_div.sv
// Sequential signed truncating divider, one quotient bit per cycle.
module rat_div (
    input  logic            clk,
    input  logic            rst_n,
    input  rat_pkg::div_req_t req,
    output rat_pkg::div_rsp_t rsp
);
    import rat_pkg::*;

    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    word_t         q_reg;
    logic [W:0]    r_reg;
    word_t         d_reg;
    logic          qneg_reg;
    logic          rneg_reg;
    logic [W:0]    trial;
    word_t         a_mag;
    word_t         b_mag;

    assign a_mag = req.dividend[W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign b_mag = req.divisor[W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
    assign trial = {r_reg[W-1:0], q_reg[W-1]} - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
                q_reg    <= a_mag;
                r_reg    <= '0;
                d_reg    <= b_mag;
                qneg_reg <= req.dividend[W-1] ^ req.divisor[W-1];
                rneg_reg <= req.dividend[W-1];
            end
            else if (busy_reg)
            begin
                if (!trial[W])
                begin
                    r_reg <= trial;
                    q_reg <= {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    r_reg <= {r_reg[W-1:0], q_reg[W-1]};
                    q_reg <= {q_reg[W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Magnitude results get the signs of C truncating division; wrapping covers
    // the most negative value divided by minus one.
    assign rsp.done = done_reg;
    assign rsp.quot = qneg_reg ? (~q_reg + 1'b1) : q_reg;
    assign rsp.rem  = rneg_reg ? (~r_reg[W-1:0] + 1'b1) : r_reg[W-1:0];

endmodule

// File: rtl/rational_accumulator_alu.sv
// Top level of the rational accumulator ALU with gcd reduction.
//
//  Channel | Dir | tdata fields (low bit first)            | tuser
//  s_axis  | in  | operation[2:0], operand_num, operand_den | none
//  m_axis  | out | result_num, result_den, equal, error     | none
//
// Load and the unused codes pass through states M0, M1 and OUT; add goes through
// M0, M1, M2 and OUT, and multiply and divide through M0, M1, M2, M3 and OUT,
// all through one shared 32x32 multiplier. Simplify runs the gcd as a chain of
// remainder steps on one shared divider, then two divisions for the parts;
// simplify of 0/0 stops after the first gcd check. Reset clears the accumulator
// to 0/1. The input is not ready while an item is at work or while its result
// waits in the output register for m_axis_tready.
module rational_accumulator_alu (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,  // operation[2:0], operand_num[34:3], operand_den[66:35]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [71:0]  m_axis_tdata   // result_num[31:0], result_den[63:32], equal[64], error[65]
);
    import rat_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_M0    = 4'd1;  // an*bd
    localparam logic [3:0] ST_M1    = 4'd2;  // bn*ad, sets equal
    localparam logic [3:0] ST_M2    = 4'd3;  // per-operation products
    localparam logic [3:0] ST_M3    = 4'd4;
    localparam logic [3:0] ST_GCD   = 4'd5;
    localparam logic [3:0] ST_GWAIT = 4'd6;
    localparam logic [3:0] ST_QN    = 4'd7;
    localparam logic [3:0] ST_QNW   = 4'd8;
    localparam logic [3:0] ST_QD    = 4'd9;
    localparam logic [3:0] ST_QDW   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [2:0] op_reg;
    word_t      bn_reg, bd_reg, an_reg, ad_reg;
    word_t      x_reg, y_reg, p0_reg, p1_reg;
    logic       eq_reg, err_reg;
    logic       ovalid_reg;
    logic [71:0] odata_reg;
    word_t      ma, mb, prod;
    div_req_t   dreq;
    div_rsp_t   drsp;

    rat_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // Shared multiplier, low 32 bits of the product.
    assign prod = ma * mb;

    always_comb
    begin
        ma = an_reg;
        mb = bd_reg;
        unique case (state_reg)
            ST_M1: begin ma = bn_reg; mb = ad_reg; end
            ST_M2:
            begin
                ma = (op_reg == OP_MUL) ? an_reg : ad_reg;
                mb = (op_reg == OP_MUL) ? bn_reg : bd_reg;
            end
            ST_M3: begin ma = ad_reg; mb = (op_reg == OP_DIV) ? bn_reg : bd_reg; end
            default: ;
        endcase
    end

    always_comb
    begin
        dreq.start    = 1'b0;
        dreq.dividend = x_reg;
        dreq.divisor  = y_reg;
        unique case (state_reg)
            ST_GCD: dreq.start = (y_reg != '0);
            ST_QN:  begin dreq.start = 1'b1; dreq.dividend = an_reg; end
            ST_QD:  begin dreq.start = 1'b1; dreq.dividend = ad_reg; end
            default: ;
        endcase
    end

    assign s_axis_tready = (state_reg == ST_IDLE) && !ovalid_reg;
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            an_reg     <= '0;
            ad_reg     <= word_t'(1);
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        op_reg    <= s_axis_tdata[2:0];
                        bn_reg    <= s_axis_tdata[34:3];
                        bd_reg    <= s_axis_tdata[66:35];
                        err_reg   <= 1'b0;
                        state_reg <= ST_M0;
                    end
                ST_M0:
                begin
                    p0_reg    <= prod;
                    state_reg <= ST_M1;
                end
                ST_M1:
                begin
                    eq_reg <= (p0_reg == prod);
                    p1_reg <= prod;
                    unique case (op_reg)
                        OP_LOAD:
                        begin
                            an_reg <= bn_reg;
                            ad_reg <= bd_reg;
                            state_reg <= ST_OUT;
                        end
                        OP_ADD, OP_MUL, OP_DIV: state_reg <= ST_M2;
                        OP_SIMPLIFY:
                        begin
                            x_reg <= an_reg;
                            y_reg <= ad_reg;
                            state_reg <= ST_GCD;
                        end
                        default: state_reg <= ST_OUT;
                    endcase
                end
                ST_M2:
                begin
                    if (op_reg == OP_ADD)
                    begin
                        an_reg <= p0_reg + p1_reg;
                        ad_reg <= prod;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        an_reg <= (op_reg == OP_MUL) ? prod : p0_reg;
                        state_reg <= ST_M3;
                    end
                end
                ST_M3:
                begin
                    ad_reg <= prod;
                    state_reg <= ST_OUT;
                end
                ST_GCD:
                    if (y_reg != '0)
                        state_reg <= ST_GWAIT;
                    else if (x_reg == '0)
                    begin
                        err_reg   <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        y_reg     <= x_reg;
                        state_reg <= ST_QN;
                    end
                ST_GWAIT:
                    if (drsp.done)
                    begin
                        x_reg <= y_reg;
                        y_reg <= (y_reg == '1) ? '0 : drsp.rem;
                        state_reg <= ST_GCD;
                    end
                ST_QN: state_reg <= ST_QNW;
                ST_QNW:
                    if (drsp.done)
                    begin
                        an_reg <= drsp.quot;
                        state_reg <= ST_QD;
                    end
                ST_QD: state_reg <= ST_QDW;
                ST_QDW:
                    if (drsp.done)
                    begin
                        if (drsp.quot[W-1])
                        begin
                            an_reg <= ~an_reg + 1'b1;
                            ad_reg <= ~drsp.quot + 1'b1;
                        end
                        else
                            ad_reg <= drsp.quot;
                        state_reg <= ST_OUT;
                    end
                ST_OUT:
                begin
                    odata_reg  <= {6'd0, err_reg, eq_reg, ad_reg, an_reg};
                    ovalid_reg <= 1'b1;
                    state_reg  <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
